FILE: sv/asq_pkg.sv
// Shared types, constants and helper functions for the angle sample
// qualifier. No dependencies.
`timescale 1ns / 1ps

package asq_pkg;

    // Angle format
    localparam int ANG_W = 14;
    localparam int CPT   = 16384;
    localparam logic signed [14:0] HALF_TURN = 15'sd8192;
    localparam logic signed [14:0] FULL_TURN = 15'sd16384;

    // Jump limit table
    localparam int LIM_W   = 13;
    localparam int DT_MAX  = 25;
    localparam int VALID_AGE_MS = 200;

    // Speed fixed point
    localparam int SPEED_W = 18;
    localparam int NUM_W   = 23;            // |diff| * 1000 fits here
    localparam logic [16:0] SPEED_MAX  = 17'd78227;
    localparam logic [17:0] SPEED_ZERO = 18'd130;
    localparam logic [19:0] RECIP5     = 20'd838861;   // ceil(2^22 / 5)
    localparam int RECIP_SH = 22;

    // Configuration register indexes
    localparam logic [2:0] REG_BOOT_WIN   = 3'd0;
    localparam logic [2:0] REG_BOOT_CNT   = 3'd1;
    localparam logic [2:0] REG_REC_WIN    = 3'd2;
    localparam logic [2:0] REG_REC_CNT    = 3'd3;
    localparam logic [2:0] REG_REC_AGE    = 3'd4;
    localparam logic [2:0] REG_SPD_RESET  = 3'd5;
    localparam logic [2:0] REG_SPD_WINDOW = 3'd6;
    localparam logic [2:0] REG_ZERO_LEVEL = 3'd7;

    typedef enum logic [2:0] {
        OC_REJECT = 3'd0,
        OC_FIRST  = 3'd1,
        OC_RETRY  = 3'd2,
        OC_RESYNC = 3'd3,
        OC_BOOT   = 3'd4
    } outcome_t;

    typedef logic [LIM_W-1:0] lim_tab_t [0:DT_MAX];

    // floor(CPT*d*60000/6283185)+4, at least 8, d clamped to 1..25
    function automatic lim_tab_t lim_table();
        lim_tab_t t;
        longint unsigned v;
        int unsigned d;
        for (int i = 0; i <= DT_MAX; i++)
        begin
            d = (i == 0) ? 1 : i;
            v = (longint'(CPT) * d * 60000) / 6283185 + 4;
            if (v < 8)
            begin
                v = 8;
            end
            t[i] = LIM_W'(v);
        end
        return t;
    endfunction

    localparam lim_tab_t JUMP_LIM = lim_table();

    // Wrap-aware angle difference a - b
    function automatic logic signed [14:0] wrap_diff(logic [ANG_W-1:0] a,
                                                     logic [ANG_W-1:0] b);
        logic signed [14:0] d;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        if (d > HALF_TURN)
        begin
            d = d - FULL_TURN;
        end
        else if (d < -HALF_TURN)
        begin
            d = d + FULL_TURN;
        end
        return d;
    endfunction

    function automatic logic [ANG_W-1:0] diff_mag(logic signed [14:0] d);
        logic [14:0] m;
        m = d[14] ? 15'(-d) : 15'(d);
        return m[ANG_W-1:0];
    endfunction

    // |wrap_diff(a, b)| <= lim
    function automatic logic near(logic [ANG_W-1:0] a, logic [ANG_W-1:0] b,
                                  logic [ANG_W-1:0] lim);
        logic signed [14:0] d;
        logic [14:0] m;
        d = wrap_diff(a, b);
        m = d[14] ? 15'(-d) : 15'(d);
        return m <= {1'b0, lim};
    endfunction

    // Jump to near zero from well above zero that is also far away
    function automatic logic glitch_far(logic [ANG_W-1:0] x, logic [ANG_W-1:0] prev,
                                        logic [ANG_W-1:0] zlev, logic [ANG_W-1:0] lim);
        return (x <= zlev) && (prev > zlev) && !near(x, prev, lim);
    endfunction

endpackage

FILE: sv/angle_sample_qualifier_speed_est.sv
// Angle sample qualifier with speed estimator, single module.
// Depends on asq_pkg.
`timescale 1ns / 1ps

// One word in gives one word out. A word passes through take, evaluate and
// output when no speed update is due, and through take, evaluate, 23 steps
// of a bit-serial restoring divider for rate = diff*1000/window_ms, filter
// and output when one is. The input is taken only while idle; the output
// register lets a finished word wait for the sink while the next word is
// taken. The outcome code rides on m_axis_tuser with angle_valid.
// Configuration writes belong to idle periods.
module angle_sample_qualifier_speed_est #(
    parameter int TIME_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // angle_sample[13:0], retry_sample[27:14],
                                        // time_ms[59:28], zero[63:60]
    input  logic [1:0]  s_axis_tuser,   // read_ok[0], retry_ok[1]
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // angle[13:0], received_angle[27:14],
                                        // speed[45:28], bad_frame_count[77:46],
                                        // drop_count[93:78], zero[95:94]
    output logic [3:0]  m_axis_tuser,   // outcome[2:0], angle_valid[3]
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int TB = TIME_BITS;
    localparam int AW = asq_pkg::ANG_W;
    localparam int SW = asq_pkg::SPEED_W;
    localparam int NW = asq_pkg::NUM_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_DIV  = 5'b00100,
        S_EMA  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    // configuration registers
    logic [7:0]    bmw_reg, bmc_reg, rmw_reg, rmc_reg;
    logic [15:0]   rma_reg, srm_reg, swm_reg;
    logic [AW-1:0] zgl_reg;

    // captured input word
    logic          in_rok_reg, in_tok_reg;
    logic [AW-1:0] in_a_reg, in_ra_reg;
    logic [TB-1:0] in_now_reg;

    // qualifier and estimator state
    state_t                state_reg, state_next;
    logic                  started_reg, started_next;
    logic [AW-1:0]         prev_angle_reg, prev_angle_next;
    logic [TB-1:0]         prev_time_reg, prev_time_next;
    logic [AW-1:0]         win_angle_reg, win_angle_next;
    logic [TB-1:0]         win_time_reg, win_time_next;
    logic                  boot_valid_reg, boot_valid_next;
    logic [AW-1:0]         boot_angle_reg, boot_angle_next;
    logic [7:0]            boot_cnt_reg, boot_cnt_next;
    logic                  rec_valid_reg, rec_valid_next;
    logic [AW-1:0]         rec_angle_reg, rec_angle_next;
    logic [7:0]            rec_cnt_reg, rec_cnt_next;
    logic signed [SW-1:0]  acc_reg, acc_next;
    logic [TB-1:0]         lct_reg, lct_next;
    logic                  have_reg, have_next;
    logic [AW-1:0]         acc_angle_reg, acc_angle_next;
    logic [AW-1:0]         last_rx_reg, last_rx_next;
    logic [31:0]           bad_reg, bad_next;
    logic [15:0]           drops_reg, drops_next;
    asq_pkg::outcome_t     oc_reg, oc_next;

    // serial divider
    logic [TB-1:0] div_rem_reg, div_rem_next;
    logic [NW-1:0] div_num_reg, div_num_next;
    logic [TB-1:0] div_den_reg, div_den_next;
    logic          div_neg_reg, div_neg_next;
    logic [4:0]    div_cnt_reg, div_cnt_next;

    // output register
    logic          out_valid_reg;
    logic [95:0]   out_tdata_reg;
    logic [3:0]    out_tuser_reg;

    // time differences and limits
    logic [TB-1:0]       age, dt, wdt, out_age;
    logic [4:0]          lim_idx;
    logic [AW-1:0]       lim, lim25;
    logic [TB-1:0]       srm_ext, swm_ext, rma_ext;

    assign age     = in_now_reg - lct_reg;
    assign dt      = in_now_reg - prev_time_reg;
    assign wdt     = in_now_reg - win_time_reg;
    assign out_age = in_now_reg - lct_reg;
    assign srm_ext = TB'(srm_reg);
    assign swm_ext = TB'(swm_reg);
    assign rma_ext = TB'(rma_reg);
    assign lim_idx = (dt == '0) ? 5'd1 :
                     ((dt > TB'(asq_pkg::DT_MAX)) ? 5'(asq_pkg::DT_MAX) : dt[4:0]);
    assign lim     = AW'(asq_pkg::JUMP_LIM[lim_idx]);
    assign lim25   = AW'(asq_pkg::JUMP_LIM[asq_pkg::DT_MAX]);

    // divider step
    logic [TB:0] rem_sh, rem_new;
    logic        q_bit;
    assign rem_sh  = {div_rem_reg, div_num_reg[NW-1]};
    assign q_bit   = rem_sh >= {1'b0, div_den_reg};
    assign rem_new = q_bit ? (rem_sh - {1'b0, div_den_reg}) : rem_sh;

    // EMA of the saturated window rate
    logic [16:0]          rate_mag;
    logic signed [19:0]   rate_s, acc_w, ema_sum;
    logic [19:0]          ema_mag;
    logic [17:0]          ema_q;
    logic signed [SW-1:0] ema_res;
    assign rate_mag = (div_num_reg > NW'(asq_pkg::SPEED_MAX)) ? asq_pkg::SPEED_MAX
                                                              : div_num_reg[16:0];
    assign rate_s   = div_neg_reg ? -$signed({3'b000, rate_mag}) : $signed({3'b000, rate_mag});
    assign acc_w    = 20'(acc_reg);
    assign ema_sum  = rate_s + acc_w + (acc_w <<< 1);
    assign ema_mag  = ema_sum[19] ? 20'(-ema_sum) : 20'(ema_sum);
    assign ema_q    = ema_mag[19:2];
    assign ema_res  = ema_sum[19] ? -$signed(ema_q) : $signed(ema_q);

    // decay by 4/5 on a bad frame, cleared when small
    logic [17:0]          acc_mag, dec_q;
    logic [39:0]          dec_prod;
    logic signed [SW-1:0] dec_res;
    assign acc_mag  = acc_reg[SW-1] ? 18'(-acc_reg) : 18'(acc_reg);
    assign dec_prod = 40'({acc_mag, 2'b00}) * 40'(asq_pkg::RECIP5);
    assign dec_q    = dec_prod[asq_pkg::RECIP_SH +: 18];
    assign dec_res  = (dec_q <= asq_pkg::SPEED_ZERO) ? '0 :
                      (acc_reg[SW-1] ? -$signed(dec_q) : $signed(dec_q));

    // qualification checks on the captured word
    logic       boot_match, rec_match, rec_block, ok_first, ok_retry;
    logic [7:0] boot_inc, rec_inc;
    assign boot_match = boot_valid_reg &&
                        asq_pkg::near(in_a_reg, boot_angle_reg, AW'(bmw_reg));
    assign boot_inc   = (boot_cnt_reg == 8'hFF) ? 8'hFF : boot_cnt_reg + 8'd1;
    assign rec_match  = rec_valid_reg &&
                        asq_pkg::near(in_ra_reg, rec_angle_reg, AW'(rmw_reg));
    assign rec_inc    = (rec_cnt_reg == 8'hFF) ? 8'hFF : rec_cnt_reg + 8'd1;
    assign rec_block  = (age < rma_ext) ||
                        asq_pkg::glitch_far(in_ra_reg, prev_angle_reg, zgl_reg, lim25);
    assign ok_first   = (dt > srm_ext) ||
                        (asq_pkg::near(in_a_reg, prev_angle_reg, lim) &&
                         !asq_pkg::glitch_far(in_a_reg, prev_angle_reg, zgl_reg, lim));
    assign ok_retry   = asq_pkg::near(in_ra_reg, prev_angle_reg, lim) &&
                        !asq_pkg::glitch_far(in_ra_reg, prev_angle_reg, zgl_reg, lim);

    // next-state logic
    always_comb
    begin
        logic              do_take;
        logic              do_bad;
        logic              restart;
        logic [AW-1:0]     take_x;
        logic [AW-1:0]     wd_mag;
        asq_pkg::outcome_t oc;

        do_take = 1'b0;
        do_bad  = 1'b0;
        restart = 1'b0;
        take_x  = in_a_reg;
        wd_mag  = '0;
        oc      = asq_pkg::OC_REJECT;

        state_next      = state_reg;
        started_next    = started_reg;
        prev_angle_next = prev_angle_reg;
        prev_time_next  = prev_time_reg;
        win_angle_next  = win_angle_reg;
        win_time_next   = win_time_reg;
        boot_valid_next = boot_valid_reg;
        boot_angle_next = boot_angle_reg;
        boot_cnt_next   = boot_cnt_reg;
        rec_valid_next  = rec_valid_reg;
        rec_angle_next  = rec_angle_reg;
        rec_cnt_next    = rec_cnt_reg;
        acc_next        = acc_reg;
        lct_next        = lct_reg;
        have_next       = have_reg;
        acc_angle_next  = acc_angle_reg;
        last_rx_next    = last_rx_reg;
        bad_next        = bad_reg;
        drops_next      = drops_reg;
        oc_next         = oc_reg;
        div_rem_next    = div_rem_reg;
        div_num_next    = div_num_reg;
        div_den_next    = div_den_reg;
        div_neg_next    = div_neg_reg;
        div_cnt_next    = div_cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                state_next = S_DONE;
                // decide the outcome
                if (!in_rok_reg)
                begin
                    do_bad = 1'b1;
                end
                else
                begin
                    last_rx_next = in_a_reg;
                    if (!started_reg)
                    begin
                        boot_angle_next = in_a_reg;
                        boot_valid_next = 1'b1;
                        if (!boot_match)
                        begin
                            boot_cnt_next = 8'd1;
                            do_bad        = 1'b1;
                        end
                        else
                        begin
                            boot_cnt_next = boot_inc;
                            if (boot_inc >= bmc_reg)
                            begin
                                do_take = 1'b1;
                                oc      = asq_pkg::OC_BOOT;
                            end
                            else
                            begin
                                do_bad = 1'b1;
                            end
                        end
                    end
                    else if (ok_first)
                    begin
                        do_take = 1'b1;
                        oc      = asq_pkg::OC_FIRST;
                    end
                    else if (in_tok_reg)
                    begin
                        last_rx_next = in_ra_reg;
                        take_x       = in_ra_reg;
                        if (ok_retry)
                        begin
                            do_take = 1'b1;
                            oc      = asq_pkg::OC_RETRY;
                        end
                        else if (rec_block)
                        begin
                            rec_valid_next = 1'b0;
                            rec_cnt_next   = 8'd0;
                            do_bad         = 1'b1;
                        end
                        else if (!rec_match)
                        begin
                            rec_angle_next = in_ra_reg;
                            rec_cnt_next   = 8'd1;
                            rec_valid_next = 1'b1;
                            do_bad         = 1'b1;
                        end
                        else
                        begin
                            rec_angle_next = in_ra_reg;
                            rec_cnt_next   = rec_inc;
                            if (rec_inc >= rmc_reg)
                            begin
                                restart = 1'b1;
                                do_take = 1'b1;
                                oc      = asq_pkg::OC_RESYNC;
                            end
                            else
                            begin
                                do_bad = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        do_bad = 1'b1;
                    end
                end

                // accept an angle
                if (do_take)
                begin
                    if (started_reg && !restart)
                    begin
                        if (dt != '0 && dt <= srm_ext)
                        begin
                            if (wdt >= swm_ext && wdt != '0)
                            begin
                                wd_mag         = asq_pkg::diff_mag(
                                                     asq_pkg::wrap_diff(take_x, win_angle_reg));
                                div_neg_next   = asq_pkg::wrap_diff(take_x, win_angle_reg) < 0;
                                div_num_next   = NW'(wd_mag) * NW'(1000);
                                div_rem_next   = '0;
                                div_den_next   = wdt;
                                div_cnt_next   = 5'(NW - 1);
                                win_angle_next = take_x;
                                win_time_next  = in_now_reg;
                                state_next     = S_DIV;
                            end
                        end
                        else if (dt > srm_ext)
                        begin
                            acc_next       = '0;
                            win_angle_next = take_x;
                            win_time_next  = in_now_reg;
                        end
                    end
                    else
                    begin
                        started_next   = 1'b1;
                        acc_next       = '0;
                        win_angle_next = take_x;
                        win_time_next  = in_now_reg;
                    end
                    prev_angle_next = take_x;
                    prev_time_next  = in_now_reg;
                    rec_valid_next  = 1'b0;
                    rec_cnt_next    = 8'd0;
                    drops_next      = 16'd0;
                    acc_angle_next  = take_x;
                    lct_next        = in_now_reg;
                    have_next       = 1'b1;
                end

                // count a bad frame
                if (do_bad)
                begin
                    if (bad_reg != 32'hFFFF_FFFF)
                    begin
                        bad_next = bad_reg + 32'd1;
                    end
                    if (drops_reg != 16'hFFFF)
                    begin
                        drops_next = drops_reg + 16'd1;
                    end
                    acc_next = dec_res;
                end
                oc_next = oc;
            end

            S_DIV:
            begin
                div_rem_next = rem_new[TB-1:0];
                div_num_next = {div_num_reg[NW-2:0], q_bit};
                div_cnt_next = div_cnt_reg - 5'd1;
                if (div_cnt_reg == 5'd0)
                begin
                    state_next = S_EMA;
                end
            end

            S_EMA:
            begin
                acc_next   = ema_res;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            started_reg    <= 1'b0;
            prev_angle_reg <= '0;
            prev_time_reg  <= '0;
            win_angle_reg  <= '0;
            win_time_reg   <= '0;
            boot_valid_reg <= 1'b0;
            boot_angle_reg <= '0;
            boot_cnt_reg   <= '0;
            rec_valid_reg  <= 1'b0;
            rec_angle_reg  <= '0;
            rec_cnt_reg    <= '0;
            acc_reg        <= '0;
            lct_reg        <= '0;
            have_reg       <= 1'b0;
            acc_angle_reg  <= '0;
            last_rx_reg    <= '0;
            bad_reg        <= '0;
            drops_reg      <= '0;
            oc_reg         <= asq_pkg::OC_REJECT;
            div_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            started_reg    <= started_next;
            prev_angle_reg <= prev_angle_next;
            prev_time_reg  <= prev_time_next;
            win_angle_reg  <= win_angle_next;
            win_time_reg   <= win_time_next;
            boot_valid_reg <= boot_valid_next;
            boot_angle_reg <= boot_angle_next;
            boot_cnt_reg   <= boot_cnt_next;
            rec_valid_reg  <= rec_valid_next;
            rec_angle_reg  <= rec_angle_next;
            rec_cnt_reg    <= rec_cnt_next;
            acc_reg        <= acc_next;
            lct_reg        <= lct_next;
            have_reg       <= have_next;
            acc_angle_reg  <= acc_angle_next;
            last_rx_reg    <= last_rx_next;
            bad_reg        <= bad_next;
            drops_reg      <= drops_next;
            oc_reg         <= oc_next;
            div_cnt_reg    <= div_cnt_next;
        end
    end

    // divider datapath and input capture
    always_ff @(posedge clk)
    begin
        div_rem_reg <= div_rem_next;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        div_neg_reg <= div_neg_next;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_rok_reg <= s_axis_tuser[0];
            in_tok_reg <= s_axis_tuser[1];
            in_a_reg   <= s_axis_tdata[13:0];
            in_ra_reg  <= s_axis_tdata[27:14];
            in_now_reg <= s_axis_tdata[28 +: TB];
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bmw_reg <= 8'd8;
            bmc_reg <= 8'd2;
            rmw_reg <= 8'd12;
            rmc_reg <= 8'd4;
            rma_reg <= 16'd30;
            srm_reg <= 16'd100;
            swm_reg <= 16'd20;
            zgl_reg <= 14'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                asq_pkg::REG_BOOT_WIN:   bmw_reg <= cfg_data[7:0];
                asq_pkg::REG_BOOT_CNT:   bmc_reg <= cfg_data[7:0];
                asq_pkg::REG_REC_WIN:    rmw_reg <= cfg_data[7:0];
                asq_pkg::REG_REC_CNT:    rmc_reg <= cfg_data[7:0];
                asq_pkg::REG_REC_AGE:    rma_reg <= cfg_data;
                asq_pkg::REG_SPD_RESET:  srm_reg <= cfg_data;
                asq_pkg::REG_SPD_WINDOW: swm_reg <= cfg_data;
                asq_pkg::REG_ZERO_LEVEL: zgl_reg <= cfg_data[13:0];
                default:                 zgl_reg <= zgl_reg;
            endcase
        end
    end

    // output register
    logic              ang_valid;
    logic [SW-1:0]     spd_out;
    assign ang_valid = have_reg && (out_age <= TB'(asq_pkg::VALID_AGE_MS));
    assign spd_out   = ang_valid ? acc_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
        begin
            out_tdata_reg <= {2'b00, drops_reg, bad_reg, spd_out, last_rx_reg, acc_angle_reg};
            out_tuser_reg <= {ang_valid, oc_reg};
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tdata_reg;
    assign m_axis_tuser  = out_tuser_reg;

endmodule
